[sv/evp_pkg.sv]
// Shared state type, widths and helper function for the encoder velocity PID block.
// Used by evp_div, evp_mul and encoder_velocity_pid; depends on nothing else.
package evp_pkg;

    localparam int CountW   = 32;
    localparam int TargetW  = 24;
    localparam int GainW    = 24;
    localparam int PeriodW  = 16;
    localparam int LimitW   = 16;
    localparam int IlimW    = 31;
    localparam int CfgW     = 31;
    localparam int CfgAddrW = 3;
    localparam int QW       = 32;
    localparam int McandW   = 34;
    localparam int ProdW    = GainW + McandW;
    localparam int NumW     = 49;
    localparam int DivCntW  = 6;
    localparam int MulCntW  = 5;
    localparam int InDataW  = 56;
    localparam int OutDataW = 56;

    localparam logic [CfgAddrW-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_PERIOD_MS   = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_DRIVE_LIMIT = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_INTEG_LIMIT = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ABS, ST_SCALE, ST_DIV, ST_VEL, ST_ERR,
        ST_DIFF, ST_MUL, ST_SUM, ST_ACC, ST_DONE
    } evp_state_t;

    function automatic logic signed [QW-1:0] sat32(input logic signed [ProdW-1:0] v);
        logic signed [ProdW-1:0] hi;
        logic signed [ProdW-1:0] lo;
        hi = ProdW'(64'sh7FFF_FFFF);
        lo = -ProdW'(64'sh8000_0000);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[QW-1:0];
    endfunction

endpackage

[sv/evp_div.sv]
// Bit-serial restoring divider: one quotient bit per clock.
// Uses evp_pkg for widths.
module evp_div
    import evp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NumW-1:0]    num,
    input  logic [PeriodW-1:0] den,
    output logic               busy,
    output logic [NumW-1:0]    quot
);

    logic [NumW-1:0]    num_reg, num_next;
    logic [NumW-1:0]    quot_reg, quot_next;
    logic [PeriodW-1:0] rem_reg, rem_next;
    logic [PeriodW-1:0] den_reg, den_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [PeriodW:0]   trial;
    logic               fits;

    always_comb
    begin
        trial     = {rem_reg, num_reg[NumW-1]};
        fits      = (trial >= {1'b0, den_reg});
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
            cnt_next  = DivCntW'(NumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[NumW-2:0], 1'b0};
            rem_next  = fits ? PeriodW'(trial - {1'b0, den_reg}) : trial[PeriodW-1:0];
            quot_next = {quot_reg[NumW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DivCntW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

[sv/evp_mul.sv]
// Bit-serial signed multiplier: one gain bit per clock, two's complement.
// Uses evp_pkg for widths.
module evp_mul
    import evp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [GainW-1:0]  gain,
    input  logic signed [McandW-1:0] mcand,
    output logic                     busy,
    output logic signed [ProdW-1:0]  prod
);

    logic [GainW-1:0]        gain_reg, gain_next;
    logic signed [ProdW-1:0] mc_reg, mc_next;
    logic signed [ProdW-1:0] acc_reg, acc_next;
    logic [MulCntW-1:0]      cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic signed [ProdW-1:0] addend;

    always_comb
    begin
        // The top gain bit carries negative weight.
        if (!gain_reg[0])
            addend = '0;
        else if (cnt_reg == MulCntW'(GainW - 1))
            addend = -mc_reg;
        else
            addend = mc_reg;
        gain_next = gain_reg;
        mc_next   = mc_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            gain_next = gain;
            mc_next   = ProdW'(mcand);
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            gain_next = {1'b0, gain_reg[GainW-1:1]};
            mc_next   = mc_reg <<< 1;
            acc_next  = acc_reg + addend;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == MulCntW'(GainW - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_reg <= gain_next;
        mc_reg   <= mc_next;
        acc_reg  <= acc_next;
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

[sv/encoder_velocity_pid.sv]
// Encoder velocity PID controller. One transaction on the input stream (encoder count and
// velocity setpoint) yields one output transaction once the bit-serial velocity divider, the
// three parallel bit-serial gain multipliers and the sequencing steps have run. One item is
// processed at a time; the next is taken once the result sits in the output register, which
// may still wait for the consumer.
module encoder_velocity_pid
    import evp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgW-1:0]     cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,  // encoder_count[31:0], target_velocity[55:32]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata   // drive_magnitude[15:0], drive_reverse[16],
                                               // measured_velocity[48:17], zero[55:49]
);

    evp_state_t state_reg, state_next;

    logic signed [GainW-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [PeriodW-1:0]      period_reg;
    logic [LimitW-1:0]       drive_limit_reg;
    logic [IlimW-1:0]        integ_limit_reg;

    logic [CountW-1:0]       last_count_reg;
    logic signed [QW-1:0]    last_error_reg, integ_reg, accum_reg;
    logic signed [QW-1:0]    last_error_next, integ_next, accum_next;

    logic signed [TargetW-1:0] target_reg;
    logic [CountW-1:0]         delta_reg, absd_reg;
    logic signed [QW-1:0]      vel_reg, err_reg, sum_reg;
    logic [LimitW-1:0]         mag_out_reg;
    logic                      rev_out_reg;
    logic signed [QW-1:0]      vel_out_reg;
    logic                      out_valid_reg, out_valid_next;

    logic                    div_start, div_busy, mul_start, mul_busy;
    logic [NumW-1:0]         num_w, div_quot;
    logic [PeriodW-1:0]      den_w;
    logic signed [QW-1:0]    vel_w, err_w;
    logic signed [McandW-1:0] mc_p, mc_d, mc_i;
    logic signed [ProdW-1:0] prod_p, prod_d, prod_i, sum_w;
    logic                    p_busy, d_busy, i_busy;
    logic signed [QW-1:0]    acc_sat, integ_sat, acc_w, integ_w;
    logic signed [QW-1:0]    lim_w, ilim_w;
    logic [LimitW-1:0]       mag_w;
    logic                    accept, load_out;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            period_reg      <= PeriodW'(1);
            drive_limit_reg <= '0;
            integ_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[GainW-1:0];
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[GainW-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[GainW-1:0];
                REG_PERIOD_MS:   period_reg      <= cfg_data[PeriodW-1:0];
                REG_DRIVE_LIMIT: drive_limit_reg <= cfg_data[LimitW-1:0];
                REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[IlimW-1:0];
                default:         ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_ABS;
            ST_ABS:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   if (!div_busy) state_next = ST_VEL;
            ST_VEL:   state_next = ST_ERR;
            ST_ERR:   state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   if (!mul_busy) state_next = ST_SUM;
            ST_SUM:   state_next = ST_ACC;
            ST_ACC:   state_next = ST_DONE;
            ST_DONE:  if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        mul_start     = 1'b0;
        case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_SCALE: div_start = 1'b1;
            ST_DIFF:  mul_start = 1'b1;
            default:  ;
        endcase
    end

    // Numerator is |delta| * 256000 = (|delta| * 125) << 11.
    assign num_w = NumW'({(({7'b0, absd_reg} << 7) - ({7'b0, absd_reg} << 1)
                          - {7'b0, absd_reg}), 11'b0});
    assign den_w = (period_reg == '0) ? PeriodW'(1) : period_reg;

    evp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_w),
        .den   (den_w),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Truncated quotient takes the sign of the count difference, then saturates.
    always_comb
    begin
        if (!delta_reg[CountW-1])
            vel_w = (div_quot[NumW-1:QW-1] != '0) ? 32'sh7FFF_FFFF : $signed(div_quot[QW-1:0]);
        else if (div_quot > NumW'(33'h1_0000_0000 >> 1))
            vel_w = 32'sh8000_0000;
        else
            vel_w = -$signed(div_quot[QW-1:0]);
    end

    assign err_w = sat32(ProdW'(target_reg) - ProdW'(vel_reg));

    assign mc_p = McandW'(err_reg);
    assign mc_d = McandW'(err_reg) - McandW'(last_error_reg);
    assign mc_i = McandW'(integ_reg);

    evp_mul u_mul_p (
        .clk   (clk), .rst_n (rst_n), .start (mul_start),
        .gain  (prop_gain_reg), .mcand (mc_p), .busy (p_busy), .prod (prod_p)
    );

    evp_mul u_mul_d (
        .clk   (clk), .rst_n (rst_n), .start (mul_start),
        .gain  (deriv_gain_reg), .mcand (mc_d), .busy (d_busy), .prod (prod_d)
    );

    evp_mul u_mul_i (
        .clk   (clk), .rst_n (rst_n), .start (mul_start),
        .gain  (integ_gain_reg), .mcand (mc_i), .busy (i_busy), .prod (prod_i)
    );

    assign mul_busy = p_busy || d_busy || i_busy;

    // An arithmetic right shift rounds toward minus infinity, as the gain scaling needs.
    assign sum_w = ProdW'(sat32(ProdW'(prod_p >>> 16)))
                 + ProdW'(sat32(ProdW'(prod_d >>> 16)))
                 + ProdW'(sat32(ProdW'(prod_i >>> 16)));

    assign lim_w     = $signed({8'b0, drive_limit_reg, 8'b0});
    assign ilim_w    = $signed({1'b0, integ_limit_reg});
    assign acc_sat   = sat32(ProdW'(accum_reg) + ProdW'(sum_reg));
    assign integ_sat = sat32(ProdW'(integ_reg) + ProdW'(err_reg));

    always_comb
    begin
        if (acc_sat > lim_w)
            acc_w = lim_w;
        else if (acc_sat < -lim_w)
            acc_w = -lim_w;
        else
            acc_w = acc_sat;

        if (target_reg == '0)
            integ_w = '0;
        else if (integ_sat > ilim_w)
            integ_w = ilim_w;
        else if (integ_sat < -ilim_w)
            integ_w = -ilim_w;
        else
            integ_w = integ_sat;

        // The accumulator is within +/- drive_limit * 256 here.
        if (!target_reg[TargetW-1] && (accum_reg > 0))
            mag_w = accum_reg[LimitW+7:8];
        else if (target_reg[TargetW-1] && (accum_reg < 0))
            mag_w = LimitW'((-accum_reg) >>> 8);
        else
            mag_w = '0;
    end

    always_comb
    begin
        last_error_next = last_error_reg;
        integ_next      = integ_reg;
        accum_next      = accum_reg;
        if (state_reg == ST_DIFF)
            last_error_next = err_reg;
        if (state_reg == ST_ACC)
        begin
            accum_next = acc_w;
            integ_next = integ_w;
        end
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_count_reg <= '0;
            last_error_reg <= '0;
            integ_reg      <= '0;
            accum_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_error_reg <= last_error_next;
            integ_reg      <= integ_next;
            accum_reg      <= accum_next;
            out_valid_reg  <= out_valid_next;
            if (accept)
                last_count_reg <= s_axis_tdata[CountW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg <= s_axis_tdata[CountW+TargetW-1:CountW];
            delta_reg  <= s_axis_tdata[CountW-1:0] - last_count_reg;
        end
        if (state_reg == ST_ABS)
            absd_reg <= delta_reg[CountW-1] ? (~delta_reg + 1'b1) : delta_reg;
        if (state_reg == ST_VEL)
            vel_reg <= vel_w;
        if (state_reg == ST_ERR)
            err_reg <= err_w;
        if (state_reg == ST_SUM)
            sum_reg <= sat32(sum_w);
        if (load_out)
        begin
            mag_out_reg <= mag_w;
            rev_out_reg <= target_reg[TargetW-1];
            vel_out_reg <= vel_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, vel_out_reg, rev_out_reg, mag_out_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_ABS))
        else $error("accepted transaction did not start the sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |=> div_busy)
        else $error("divider did not start");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIFF) |=> (mul_busy && !div_busy))
        else $error("multipliers did not start or divider still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_DONE))
        else $error("result presented outside the final step");

endmodule
